### hdl/oph_pkg.sv
// ----------------------------------------------------------------------------
// Ordinal pattern histogram package
// Shared widths, types, operation and status codes, and small helper functions.
// ----------------------------------------------------------------------------
package oph_pkg;

    localparam int MAX_EMBEDDING = 6;
    localparam int MAX_DELAY     = 16;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int COUNT_WIDTH   = 32;

    // The delay line holds every sample older than the newest one in a window.
    localparam int LINE_CELLS = MAX_EMBEDDING - 1;
    localparam int LINE_TAPS  = LINE_CELLS * MAX_DELAY;
    localparam int TAP_IW     = $clog2(LINE_TAPS);
    localparam int SEEN_MAX   = LINE_TAPS + 1;
    localparam int SEEN_W     = $clog2(SEEN_MAX + 1);
    localparam int POS_W      = $clog2(MAX_EMBEDDING + 1);

    localparam int DIM_W      = 3;
    localparam int DELAY_W    = 5;
    localparam int TIE_W      = 2;
    localparam int OP_W       = 2;
    localparam int BIN_W      = 10;
    localparam int RANK_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    function automatic int unsigned factorial(input int unsigned n);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= n; i++)
        begin
            f = f * i;
        end
        return f;
    endfunction

    localparam int NUM_BINS = factorial(MAX_EMBEDDING);
    localparam int ADDR_W   = $clog2(NUM_BINS);

    // Digit weights 0! .. (MAX_EMBEDDING-1)! as a constant table.
    typedef logic [MAX_EMBEDDING-1:0][RANK_W-1:0] fact_lut_t;

    function automatic fact_lut_t build_fact_lut();
        fact_lut_t t;
        for (int i = 0; i < MAX_EMBEDDING; i++)
        begin
            t[i] = RANK_W'(factorial(unsigned'(i)));
        end
        return t;
    endfunction

    localparam fact_lut_t FACT_LUT = build_fact_lut();

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [COUNT_WIDTH-1:0]         count_t;
    typedef logic [RANK_W-1:0]              rank_t;
    typedef logic [ADDR_W-1:0]              addr_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 2'd0,
        ST_TIED_WINDOW    = 2'd1,
        ST_COUNT_OVERFLOW = 2'd2,
        ST_TOO_FEW        = 2'd3
    } status_e;

    localparam logic [TIE_W-1:0] TIE_OMIT  = 2'd1;
    localparam logic [TIE_W-1:0] TIE_RAISE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EMBED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE   = 2'd2;

    localparam logic [DIM_W-1:0]   EMBED_RESET = 3'd3;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 5'd1;

    function automatic count_t sat_inc(input count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

### hdl/oph_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation item into the block.
// ----------------------------------------------------------------------------
interface oph_req_if;
    import oph_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    sample_t             sample;
    logic [BIN_W-1:0]    bin_index;

    modport source (output valid, output op, output sample, output bin_index, input ready);
    modport sink   (input valid, input op, input sample, input bin_index, output ready);
endinterface

### hdl/oph_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item out of the block.
// ----------------------------------------------------------------------------
interface oph_rsp_if;
    import oph_pkg::*;

    logic                valid;
    logic                ready;
    logic                window_ready;
    rank_t               pattern_rank;
    logic                window_tied;
    logic                window_counted;
    count_t              bin_count;
    count_t              count_total;
    count_t              count_valid;
    count_t              count_tied;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output window_ready, output pattern_rank,
                    output window_tied, output window_counted, output bin_count,
                    output count_total, output count_valid, output count_tied,
                    output status, input ready);
    modport sink   (input valid, input window_ready, input pattern_rank,
                    input window_tied, input window_counted, input bin_count,
                    input count_total, input count_valid, input count_tied,
                    input status, output ready);
endinterface

### hdl/oph_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface oph_cfg_if;
    import oph_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/oph_cell.sv
// ----------------------------------------------------------------------------
// Delay line cell
// One segment of the sample delay line; shifts on each push and hands its
// oldest sample to the next cell.
// ----------------------------------------------------------------------------
module oph_cell (
    input  logic                                                 clk,
    input  logic                                                 shift_en,
    input  oph_pkg::sample_t                                     din,
    output oph_pkg::sample_t                                     dout,
    output logic [oph_pkg::MAX_DELAY-1:0][oph_pkg::SAMPLE_WIDTH-1:0] taps
);
    import oph_pkg::*;

    sample_t seg_reg [MAX_DELAY];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            seg_reg[0] <= din;
            for (int i = 1; i < MAX_DELAY; i++)
            begin
                seg_reg[i] <= seg_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DELAY; i++)
        begin
            taps[i] = seg_reg[i];
        end
    end

    assign dout = seg_reg[MAX_DELAY-1];
endmodule

### hdl/oph_ram.sv
// ----------------------------------------------------------------------------
// Histogram RAM
// Single write port, single read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module oph_ram #(
    parameter int DEPTH = 720,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hdl/ordinal_pattern_histogram.sv
// ----------------------------------------------------------------------------
// Ordinal pattern histogram
// Streaming ordinal pattern ranking with a saturating histogram of patterns.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side is not
// stalled and no clear is pending or running, and presents one result item
// for each, in order, through stages 1, 2 and 3 and the output register.
// A push shifts the sample into a chain of delay cells, picks the window taps,
// compares every pair of window samples, forms the Lehmer rank, and does one
// read-modify-write of the histogram RAM; a read fetches one bin through the
// same RAM port. The histogram RAM has one port pair, which sets the rate of
// one item per cycle. After reset and after each clear item, the block runs a
// clearing pass over all NUM_BINS entries of the histogram RAM, during which
// no item is accepted; configuration writes are always taken.
// ----------------------------------------------------------------------------
module ordinal_pattern_histogram (
    input  logic      clk,
    input  logic      rst_n,
    oph_req_if.sink   req,
    oph_rsp_if.source rsp,
    oph_cfg_if.sink   cfg
);
    import oph_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   embed_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIE_W-1:0]   tie_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            embed_reg <= EMBED_RESET;
            delay_reg <= DELAY_RESET;
            tie_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_EMBED)
            begin
                embed_reg <= cfg.data[DIM_W-1:0];
            end
            else if (cfg.index == CFG_DELAY)
            begin
                delay_reg <= cfg.data;
            end
            else if (cfg.index == CFG_TIE)
            begin
                tie_reg <= cfg.data[TIE_W-1:0];
            end
        end
    end

    // Clamp out-of-range settings into the supported range.
    logic [DIM_W-1:0]   dim_eff;
    logic [DELAY_W-1:0] delay_eff;

    always_comb
    begin
        if (embed_reg < DIM_W'(2))
            dim_eff = DIM_W'(2);
        else if (int'(embed_reg) > MAX_EMBEDDING)
            dim_eff = DIM_W'(MAX_EMBEDDING);
        else
            dim_eff = embed_reg;

        if (delay_reg == '0)
            delay_eff = DELAY_W'(1);
        else if (int'(delay_reg) > MAX_DELAY)
            delay_eff = DELAY_W'(MAX_DELAY);
        else
            delay_eff = delay_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next one has room
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic adv3, r3, mv23, r2, mv12, r1;
    logic block_reg, clearing_reg;
    logic acc, push_acc;

    assign adv3 = s3_v_reg & (~out_v_reg | rsp.ready);
    assign r3   = ~s3_v_reg | adv3;
    assign mv23 = s2_v_reg & r3;
    assign r2   = ~s2_v_reg | mv23;
    assign mv12 = s1_v_reg & r2;
    assign r1   = ~s1_v_reg | mv12;

    assign req.ready = r1 & ~block_reg & ~clearing_reg;
    assign acc       = req.valid & req.ready;
    assign push_acc  = acc & (op_e'(req.op) == OP_PUSH);

    // ------------------------------------------------------------------
    // Delay line: a chain of cells, shifted on each push
    // ------------------------------------------------------------------
    sample_t                                          cell_dout [LINE_CELLS];
    logic [LINE_CELLS-1:0][MAX_DELAY-1:0][SAMPLE_WIDTH-1:0] cell_taps;
    logic [LINE_TAPS-1:0][SAMPLE_WIDTH-1:0]           line_flat;

    for (genvar c = 0; c < LINE_CELLS; c++)
    begin : g_cell
        sample_t cin;
        if (c == 0)
        begin : g_head
            assign cin = req.sample;
        end
        else
        begin : g_link
            assign cin = cell_dout[c-1];
        end
        oph_cell u_cell (
            .clk      (clk),
            .shift_en (push_acc),
            .din      (cin),
            .dout     (cell_dout[c]),
            .taps     (cell_taps[c])
        );
    end

    always_comb
    begin
        for (int c = 0; c < LINE_CELLS; c++)
        begin
            for (int i = 0; i < MAX_DELAY; i++)
            begin
                line_flat[c*MAX_DELAY+i] = cell_taps[c][i];
            end
        end
    end

    // Samples seen since clear; saturate once every span is covered.
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [SEEN_W-1:0] span;
    logic              win_done;

    assign seen_next = (seen_reg == SEEN_W'(SEEN_MAX)) ? seen_reg : seen_reg + 1'b1;
    assign span      = SEEN_W'((int'(dim_eff) - 1) * int'(delay_eff));
    assign win_done  = seen_next > span;

    // Window taps, oldest first; element k is (m-1-k)*delay samples old.
    sample_t win [MAX_EMBEDDING];

    always_comb
    begin
        int age;
        for (int k = 0; k < MAX_EMBEDDING; k++)
        begin
            age = (int'(dim_eff) - 1 - k) * int'(delay_eff);
            if (k < int'(dim_eff) && age > 0)
                win[k] = line_flat[TAP_IW'(age - 1)];
            else
                win[k] = req.sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window captured
    // ------------------------------------------------------------------
    op_e              s1_op_reg;
    logic [BIN_W-1:0] s1_bin_reg;
    logic             s1_wr_reg;
    sample_t          s1_win_reg [MAX_EMBEDDING];

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg  <= op_e'(req.op);
            s1_bin_reg <= req.bin_index;
            s1_wr_reg  <= push_acc & win_done;
            for (int k = 0; k < MAX_EMBEDDING; k++)
            begin
                s1_win_reg[k] <= win[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pairwise compare matrix
    // ------------------------------------------------------------------
    logic [MAX_EMBEDDING-1:0][MAX_EMBEDDING-1:0] gt;
    logic                                        tied;

    always_comb
    begin
        gt   = '0;
        tied = 1'b0;
        for (int i = 0; i < MAX_EMBEDDING; i++)
        begin
            for (int j = i + 1; j < MAX_EMBEDDING; j++)
            begin
                gt[i][j] = s1_win_reg[i] > s1_win_reg[j];
                if (j < int'(dim_eff) && s1_win_reg[i] == s1_win_reg[j])
                    tied = 1'b1;
            end
        end
    end

    op_e                                         s2_op_reg;
    logic [BIN_W-1:0]                            s2_bin_reg;
    logic                                        s2_wr_reg;
    logic                                        s2_tied_reg;
    logic [MAX_EMBEDDING-1:0][MAX_EMBEDDING-1:0] s2_gt_reg;

    always_ff @(posedge clk)
    begin
        if (mv12)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_bin_reg  <= s1_bin_reg;
            s2_wr_reg   <= s1_wr_reg;
            s2_tied_reg <= tied;
            s2_gt_reg   <= gt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: Lehmer rank and histogram read
    // For window element x: pos = elements ordered before x, and the digit
    // counts earlier elements that sort after x. The digit weighs
    // (m-1-pos)!, taken from a constant table.
    // ------------------------------------------------------------------
    rank_t rank;
    addr_t rd_addr;
    logic  bin_ok;

    always_comb
    begin
        int               pos;
        int               dig;
        logic [POS_W-1:0] fidx;
        rank = '0;
        for (int x = 0; x < MAX_EMBEDDING; x++)
        begin
            pos  = 0;
            dig  = 0;
            fidx = '0;
            for (int y = 0; y < MAX_EMBEDDING; y++)
            begin
                if (y < x)
                begin
                    if (s2_gt_reg[y][x])
                        dig = dig + 1;
                    else
                        pos = pos + 1;
                end
                else if (y > x && y < int'(dim_eff))
                begin
                    if (s2_gt_reg[x][y])
                        pos = pos + 1;
                end
            end
            if (x < int'(dim_eff))
            begin
                fidx = POS_W'(int'(dim_eff) - 1 - pos);
                rank = rank + RANK_W'(dig * int'(FACT_LUT[fidx]));
            end
        end
    end

    assign bin_ok  = int'(s2_bin_reg) < NUM_BINS;
    assign rd_addr = (s2_op_reg == OP_PUSH) ? rank[ADDR_W-1:0] :
                     (bin_ok ? s2_bin_reg[ADDR_W-1:0] : '0);

    op_e   s3_op_reg;
    logic  s3_wr_reg;
    logic  s3_tied_reg;
    logic  s3_bin_ok_reg;
    rank_t s3_rank_reg;
    addr_t s3_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mv23)
        begin
            s3_op_reg     <= s2_op_reg;
            s3_wr_reg     <= s2_wr_reg;
            s3_tied_reg   <= s2_tied_reg;
            s3_bin_ok_reg <= bin_ok;
            s3_rank_reg   <= rank;
            s3_addr_reg   <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Histogram RAM with clearing pass and write forwarding
    // ------------------------------------------------------------------
    count_t mem_rdata;
    logic   mem_we;
    addr_t  mem_waddr;
    count_t mem_wdata;
    logic   hist_we;
    count_t bin_new;
    addr_t  clr_cnt_reg;

    logic   fwd_v_reg;
    addr_t  fwd_addr_reg;
    count_t fwd_data_reg;
    count_t bin_old;

    assign bin_old = (fwd_v_reg && fwd_addr_reg == s3_addr_reg) ? fwd_data_reg : mem_rdata;

    assign mem_we    = clearing_reg | hist_we;
    assign mem_waddr = clearing_reg ? clr_cnt_reg : s3_addr_reg;
    assign mem_wdata = clearing_reg ? '0 : bin_new;

    oph_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH (COUNT_WIDTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mv23),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (mv23)
        begin
            fwd_addr_reg <= s3_addr_reg;
            fwd_data_reg <= bin_new;
        end
    end

    // ------------------------------------------------------------------
    // Counter update and result forming
    // ------------------------------------------------------------------
    count_t total_reg, valid_reg, tiedc_reg;
    logic   ovf_reg;
    count_t total_next, valid_next, tiedc_next;
    logic   ovf_next;
    logic   counted;
    count_t bin_out;
    logic   raised_now, raised_next;
    count_t valid_report;
    status_e status_next;

    always_comb
    begin
        total_next = total_reg;
        valid_next = valid_reg;
        tiedc_next = tiedc_reg;
        ovf_next   = ovf_reg;
        bin_new    = bin_old;
        counted    = 1'b0;
        hist_we    = 1'b0;
        bin_out    = '0;
        raised_now = (tie_reg == TIE_RAISE) && (tiedc_reg != '0);

        unique case (s3_op_reg)
            OP_PUSH:
            begin
                if (s3_wr_reg)
                begin
                    total_next = sat_inc(total_reg);
                    if (total_reg == '1)
                        ovf_next = 1'b1;
                    if (s3_tied_reg)
                    begin
                        tiedc_next = sat_inc(tiedc_reg);
                        if (tiedc_reg == '1)
                            ovf_next = 1'b1;
                    end
                    counted = ~(s3_tied_reg && tie_reg == TIE_OMIT);
                    if (counted)
                    begin
                        bin_new    = sat_inc(bin_old);
                        valid_next = sat_inc(valid_reg);
                        hist_we    = adv3;
                        if (bin_old == '1 || valid_reg == '1)
                            ovf_next = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (!raised_now && s3_bin_ok_reg)
                    bin_out = bin_old;
            end
            OP_CLEAR:
            begin
                total_next = '0;
                valid_next = '0;
                tiedc_next = '0;
                ovf_next   = 1'b0;
            end
            OP_NOP:
            begin
                // leave state untouched
            end
        endcase

        raised_next = (tie_reg == TIE_RAISE) && (tiedc_next != '0);
        if (raised_next)
            valid_report = (tiedc_next > total_next) ? '0 : total_next - tiedc_next;
        else
            valid_report = valid_next;

        if (total_next == '0)
            status_next = ST_TOO_FEW;
        else if (raised_next)
            status_next = ST_TIED_WINDOW;
        else if (ovf_next)
            status_next = ST_COUNT_OVERFLOW;
        else
            status_next = ST_OK;
    end

    // Output register payload
    logic                window_ready_reg;
    rank_t               pattern_rank_reg;
    logic                window_tied_reg;
    logic                window_counted_reg;
    count_t              bin_count_reg;
    count_t              total_out_reg;
    count_t              valid_out_reg;
    count_t              tied_out_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            window_ready_reg   <= s3_wr_reg;
            pattern_rank_reg   <= s3_wr_reg ? s3_rank_reg : '0;
            window_tied_reg    <= s3_wr_reg & s3_tied_reg;
            window_counted_reg <= s3_wr_reg & counted;
            bin_count_reg      <= bin_out;
            total_out_reg      <= total_next;
            valid_out_reg      <= valid_report;
            tied_out_reg       <= tiedc_next;
            status_reg         <= status_next;
        end
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.window_ready   = window_ready_reg;
    assign rsp.pattern_rank   = pattern_rank_reg;
    assign rsp.window_tied    = window_tied_reg;
    assign rsp.window_counted = window_counted_reg;
    assign rsp.bin_count      = bin_count_reg;
    assign rsp.count_total    = total_out_reg;
    assign rsp.count_valid    = valid_out_reg;
    assign rsp.count_tied     = tied_out_reg;
    assign rsp.status         = status_reg;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic clear_done;
    assign clear_done = adv3 && s3_op_reg == OP_CLEAR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            fwd_v_reg    <= 1'b0;
            seen_reg     <= '0;
            block_reg    <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            total_reg    <= '0;
            valid_reg    <= '0;
            tiedc_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_v_reg <= acc | (s1_v_reg & ~mv12);
            s2_v_reg <= mv12 | (s2_v_reg & ~mv23);
            s3_v_reg <= mv23 | (s3_v_reg & ~adv3);
            out_v_reg <= adv3 | (out_v_reg & ~rsp.ready);

            // capture the write that lands as the next item reads the RAM
            if (mv23)
                fwd_v_reg <= hist_we;

            // hold new items from a clear until its result leaves stage 3
            if (push_acc)
                seen_reg <= seen_next;
            else if (acc && op_e'(req.op) == OP_CLEAR)
            begin
                seen_reg  <= '0;
                block_reg <= 1'b1;
            end

            if (adv3)
            begin
                total_reg <= total_next;
                valid_reg <= valid_next;
                tiedc_reg <= tiedc_next;
                ovf_reg   <= ovf_next;
            end

            if (clear_done)
            begin
                block_reg    <= 1'b0;
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (clearing_reg)
            begin
                if (int'(clr_cnt_reg) == NUM_BINS - 1)
                    clearing_reg <= 1'b0;
                else
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end
endmodule

### tb/sv/oph_pattern_checker.sv
// ----------------------------------------------------------------------------
// Ordinal pattern checker
// Watches the request, result and register channels, predicts every result
// item from its own copy of the delay line, histogram and counters, and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module oph_pattern_checker (
    input  logic clk,
    input  logic rst_n,
    oph_req_if   req,
    oph_rsp_if   rsp,
    oph_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import oph_pkg::*;

    localparam int DEPTH = LINE_TAPS + 1;

    typedef struct packed {
        logic          window_ready;
        rank_t         pattern_rank;
        logic          window_tied;
        logic          window_counted;
        count_t        bin_count;
        count_t        count_total;
        count_t        count_valid;
        count_t        count_tied;
        status_e       status;
    } pattern_result_t;

    pattern_result_t outstanding_results[$];

    logic [DIM_W-1:0]   embed_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TIE_W-1:0]   tie_reg;

    sample_t     delay_line [DEPTH];
    int          line_head;
    count_t      seen_count;
    count_t      bin_hits [NUM_BINS];
    count_t      total_cnt;
    count_t      valid_cnt;
    count_t      tied_cnt;
    logic        overflow_flag;

    int unsigned fact_of [MAX_EMBEDDING + 1] = '{1, 1, 2, 6, 24, 120, 720};

    function automatic void clear_model();
        foreach (delay_line[i]) delay_line[i] = '0;
        foreach (bin_hits[i]) bin_hits[i] = '0;
        line_head     = 0;
        seen_count    = '0;
        total_cnt     = '0;
        valid_cnt     = '0;
        tied_cnt      = '0;
        overflow_flag = 1'b0;
    endfunction

    function automatic count_t bump(count_t c);
        if (c == '1)
        begin
            overflow_flag = 1'b1;
            return c;
        end
        return c + 1'b1;
    endfunction

    function automatic pattern_result_t predict_pattern_result(logic [OP_W-1:0] op,
                                                               sample_t smp,
                                                               logic [BIN_W-1:0] bin);
        pattern_result_t r;
        sample_t         win [MAX_EMBEDDING];
        int              perm [MAX_EMBEDDING];
        int              m, d, newest, pos, age, smaller;
        int unsigned     rank;
        logic            tied, raised;

        r = '0;
        raised = (tie_reg == TIE_RAISE) && (tied_cnt != 0);
        if (op == OP_PUSH)
        begin
            m = (embed_reg < 2) ? 2 : (embed_reg > MAX_EMBEDDING) ? MAX_EMBEDDING : embed_reg;
            d = (delay_reg < 1) ? 1 : (delay_reg > MAX_DELAY) ? MAX_DELAY : delay_reg;
            newest = line_head;
            delay_line[newest] = smp;
            line_head = (newest + 1 >= DEPTH) ? 0 : newest + 1;
            if (seen_count != '1)
                seen_count = seen_count + 1'b1;
            if (seen_count > (m - 1) * d)
            begin
                tied = 1'b0;
                // gather the window oldest first
                for (int i = 0; i < m; i++)
                begin
                    age = (m - 1 - i) * d;
                    win[i] = delay_line[(newest + DEPTH - age) % DEPTH];
                end
                // stable argsort: sorted position from value, then original index
                for (int i = 0; i < m; i++)
                begin
                    pos = 0;
                    for (int j = 0; j < m; j++)
                    begin
                        if (j != i && win[j] == win[i])
                            tied = 1'b1;
                        if (win[j] < win[i] || (win[j] == win[i] && j < i))
                            pos++;
                    end
                    perm[pos] = i;
                end
                rank = 0;
                for (int i = 0; i + 1 < m; i++)
                begin
                    smaller = 0;
                    for (int j = i + 1; j < m; j++)
                        if (perm[j] < perm[i])
                            smaller++;
                    rank += smaller * fact_of[m - 1 - i];
                end
                total_cnt = bump(total_cnt);
                if (tied)
                    tied_cnt = bump(tied_cnt);
                r.window_counted = !(tied && tie_reg == TIE_OMIT);
                if (r.window_counted)
                begin
                    bin_hits[rank] = bump(bin_hits[rank]);
                    valid_cnt = bump(valid_cnt);
                end
                r.window_ready = 1'b1;
                r.pattern_rank = rank_t'(rank);
                r.window_tied  = tied;
            end
        end
        else if (op == OP_READ)
        begin
            if (!raised && bin < NUM_BINS)
                r.bin_count = bin_hits[bin];
        end
        else if (op == OP_CLEAR)
        begin
            clear_model();
        end

        // counters and status reflect the state after the update
        raised = (tie_reg == TIE_RAISE) && (tied_cnt != 0);
        r.count_total = total_cnt;
        r.count_tied  = tied_cnt;
        r.count_valid = raised ? ((tied_cnt > total_cnt) ? '0 : total_cnt - tied_cnt)
                               : valid_cnt;
        if (total_cnt == 0)
            r.status = ST_TOO_FEW;
        else if (raised)
            r.status = ST_TIED_WINDOW;
        else if (overflow_flag)
            r.status = ST_COUNT_OVERFLOW;
        else
            r.status = ST_OK;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pattern_result_t exp_r;
        if (!rst_n)
        begin
            embed_reg  = EMBED_RESET;
            delay_reg  = DELAY_RESET;
            tie_reg    = '0;
            fail_count = 0;
            outstanding_results.delete();
            clear_model();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_EMBED: embed_reg = cfg.data[DIM_W-1:0];
                    CFG_DELAY: delay_reg = cfg.data[DELAY_W-1:0];
                    CFG_TIE:   tie_reg   = cfg.data[TIE_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                outstanding_results.push_back(
                    predict_pattern_result(req.op, req.sample, req.bin_index));
            if (rsp.valid && rsp.ready)
            begin
                if (outstanding_results.size() == 0)
                begin
                    $display("%0t: result item with no expectation waiting", $time);
                    fail_count++;
                end
                else
                begin
                    exp_r = outstanding_results.pop_front();
                    check_field("window_ready", exp_r.window_ready, rsp.window_ready);
                    check_field("pattern_rank", exp_r.pattern_rank, rsp.pattern_rank);
                    check_field("window_tied", exp_r.window_tied, rsp.window_tied);
                    check_field("window_counted", exp_r.window_counted, rsp.window_counted);
                    check_field("bin_count", exp_r.bin_count, rsp.bin_count);
                    check_field("count_total", exp_r.count_total, rsp.count_total);
                    check_field("count_valid", exp_r.count_valid, rsp.count_valid);
                    check_field("count_tied", exp_r.count_tied, rsp.count_tied);
                    check_field("status", exp_r.status, rsp.status);
                end
            end
        end
        pending = outstanding_results.size();
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Ordinal pattern histogram testbench
// Drives pushes, reads, clears and no-ops under a sweep of window length,
// delay and tie policy settings with random idling on both sides; the checker
// predicts and compares every result item, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import oph_pkg::*;

    // cycles with no handshake on any channel before the run is declared hung;
    // covers a clearing pass, the long result hold-off and idle gaps
    localparam int HANG_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    bit   idling_on = 1'b1;
    bit   hold_request = 1'b0;

    oph_req_if req ();
    oph_rsp_if rsp ();
    oph_cfg_if cfg ();

    ordinal_pattern_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    oph_pattern_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold every input at a known value from time zero.
    initial
    begin
        req.valid     = 1'b0;
        req.op        = OP_NOP;
        req.sample    = '0;
        req.bin_index = '0;
        cfg.valid     = 1'b0;
        cfg.index     = CFG_EMBED;
        cfg.data      = '0;
        rsp.ready     = 1'b0;
    end

    // Send one request item: idle a random gap, then offer it until taken.
    task automatic send_item(op_e op, sample_t smp, logic [BIN_W-1:0] bin);
        int gap;
        gap = idling_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     = 1'b1;
        req.op        = op;
        req.sample    = smp;
        req.bin_index = bin;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    // Write one register; only called with nothing in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Pause the sender until every outstanding result has come back.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly small values so windows tie often, with full-range and extremes mixed in.
    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return sample_t'($signed($urandom_range(0, 8)) - 4);
        else if (sel < 90)
            return sample_t'($urandom);
        else if (sel < 95)
            return sample_t'(32'h8000_0000);
        return sample_t'(32'h7FFF_FFFF);
    endfunction

    task automatic random_item(int clear_odds);
        int sel;
        sel = $urandom_range(0, 999);
        if (sel < clear_odds)
            send_item(OP_CLEAR, sample_t'($urandom), BIN_W'($urandom));
        else if (sel < 30)
            send_item(OP_NOP, sample_t'($urandom), BIN_W'($urandom));
        else if (sel < 150)
            send_item(OP_READ, sample_t'($urandom), BIN_W'($urandom_range(0, 1023)));
        else
            send_item(OP_PUSH, pick_sample(), BIN_W'($urandom));
    endtask

    // Result side: draw a stall per item, honor a long hold-off when asked.
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready = 1'b1;
            end
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                stall = idling_on ? $urandom_range(0, 18) : 0;
        end
    end

    // Hang detection: count cycles in which no channel moves an item.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        // embedding, delay and tie policy per phase; raw values past the
        // legal range check the clamping and policy three acting as stable
        logic [CFG_DATA_W-1:0] phase_cfg [10][3] = '{
            '{5'd3, 5'd1, 5'd0}, '{5'd2, 5'd1, 5'd0}, '{5'd6, 5'd16, 5'd1},
            '{5'd6, 5'd1, 5'd2}, '{5'd2, 5'd16, 5'd2}, '{5'd0, 5'd0, 5'd3},
            '{5'd31, 5'd31, 5'd1}, '{5'd4, 5'd5, 5'd0}, '{5'd13, 5'd3, 5'd2},
            '{5'd3, 5'd2, 5'd1}};
        int clear_odds;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty reads, extremes, ties, descending run, bins past the end.
        idling_on = 1'b0;
        send_item(OP_READ, '0, '0);
        send_item(OP_NOP, '1, '1);
        send_item(OP_PUSH, sample_t'(32'h8000_0000), '0);
        send_item(OP_PUSH, sample_t'(32'h7FFF_FFFF), '0);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_PUSH, 32'sd5, '0);
        send_item(OP_PUSH, 32'sd4, '0);
        send_item(OP_PUSH, 32'sd3, '0);
        send_item(OP_PUSH, -32'sd1, '0);
        send_item(OP_READ, '0, 10'd0);
        send_item(OP_READ, '0, 10'd5);
        send_item(OP_READ, '0, 10'd719);
        send_item(OP_READ, '0, 10'd720);
        send_item(OP_READ, '0, 10'd1023);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_READ, '0, 10'd0);
        drain();

        foreach (phase_cfg[p])
        begin
            // registers change only with nothing in flight; no clear, so
            // windows may straddle the change as the block allows
            drain();
            write_reg(CFG_EMBED, phase_cfg[p][0]);
            write_reg(CFG_DELAY, phase_cfg[p][1]);
            write_reg(CFG_TIE, phase_cfg[p][2]);
            idling_on = (p % 3 != 2);
            // long spans need many pushes before a window, so clear less often
            clear_odds = (phase_cfg[p][1] > 8) ? 3 : 12;

            if (p == 1)
            begin
                // fill the block: hold results off while pushes keep coming
                hold_request = 1'b1;
                idling_on = 1'b0;
                repeat (40) send_item(OP_PUSH, pick_sample(), '0);
                idling_on = 1'b1;
            end
            repeat (PHASE_ITEMS) random_item(clear_odds);
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/oph_pkg.sv
hdl/oph_req_if.sv
hdl/oph_rsp_if.sv
hdl/oph_cfg_if.sv
hdl/oph_cell.sv
hdl/oph_ram.sv
hdl/ordinal_pattern_histogram.sv
tb/sv/oph_pattern_checker.sv
tb/sv/testbench.sv
